>>> design/xs20_pkg.sv
// Shared constants and round functions for the XSalsa20 keystream unit.
`default_nettype none
package xs20_pkg;
    localparam int NumCfg = 7;
    localparam int CfgIdxW = 3;

    typedef enum logic [CfgIdxW-1:0] {
        REG_KEY0   = 3'd0,
        REG_KEY1   = 3'd1,
        REG_KEY2   = 3'd2,
        REG_KEY3   = 3'd3,
        REG_NONCE0 = 3'd4,
        REG_NONCE1 = 3'd5,
        REG_NONCE2 = 3'd6
    } cfg_idx_t;

    typedef logic [31:0] word_t;
    typedef word_t [15:0] state_t;

    localparam word_t Sig0 = 32'h61707865;
    localparam word_t Sig1 = 32'h3320646e;
    localparam word_t Sig2 = 32'h79622d32;
    localparam word_t Sig3 = 32'h6b206574;

    function automatic word_t rotl(input word_t v, input int s);
        rotl = (v << s) | (v >> (32 - s));
    endfunction

    function automatic state_t quarter(input state_t w, input int a, input int b,
                                       input int c, input int d);
        state_t r;
        r = w;
        r[b] = r[b] ^ rotl(r[a] + r[d], 7);
        r[c] = r[c] ^ rotl(r[b] + r[a], 9);
        r[d] = r[d] ^ rotl(r[c] + r[b], 13);
        r[a] = r[a] ^ rotl(r[d] + r[c], 18);
        quarter = r;
    endfunction

    // One column round (odd=0) or one row round (odd=1).
    function automatic state_t half_round(input state_t w, input logic odd);
        state_t r;
        r = w;
        if (!odd)
        begin
            r = quarter(r, 0, 4, 8, 12);
            r = quarter(r, 5, 9, 13, 1);
            r = quarter(r, 10, 14, 2, 6);
            r = quarter(r, 15, 3, 7, 11);
        end
        else
        begin
            r = quarter(r, 0, 1, 2, 3);
            r = quarter(r, 5, 6, 7, 4);
            r = quarter(r, 10, 11, 8, 9);
            r = quarter(r, 15, 12, 13, 14);
        end
        half_round = r;
    endfunction
endpackage
`default_nettype wire

>>> design/xsalsa20_keystream_generator_unit.sv
// XSalsa20 keystream generator: round-unrolled pipeline, one block per cycle.
//
// Usage:
//   Write key_word0..3 and nonce_word0..2 through cfg_we/cfg_index/cfg_data
//   while no transaction is in flight. Register index i is the i-th register;
//   indexes beyond the list are ignored.
//   Pulse start with block_index and valid_bytes; busy is always low, so a
//   transaction is accepted on every cycle that start is high.
//   The result appears on stream_bytes0..7 and byte_count for one cycle with
//   done high, once the transaction has passed through every pipeline stage.
// Throughput: one transaction per cycle. Each pipeline stage holds one
//   column or row half round, so both the HSalsa20 and the Salsa20 chains
//   have 2*DOUBLE_ROUNDS stages; one more stage adds the feed-forward and
//   one registers the masked output.
// HSalsa20 uses only configuration, yet it runs in the pipeline alongside
//   each transaction so a result never depends on hidden precomputation.
// Reset clears the configuration registers and all stage valid bits; data
//   registers are not reset. The receiver cannot stall; done is a strobe.
`default_nettype none
module xsalsa20_keystream_generator_unit
    import xs20_pkg::*;
#(
    parameter int DOUBLE_ROUNDS = 10
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [63:0] block_index,
    input  wire logic [6:0]  valid_bytes,
    output logic             done,
    output logic [63:0]      stream_bytes0,
    output logic [63:0]      stream_bytes1,
    output logic [63:0]      stream_bytes2,
    output logic [63:0]      stream_bytes3,
    output logic [63:0]      stream_bytes4,
    output logic [63:0]      stream_bytes5,
    output logic [63:0]      stream_bytes6,
    output logic [63:0]      stream_bytes7,
    output logic [6:0]       byte_count
);
    localparam int Half = 2 * DOUBLE_ROUNDS;

    logic [NumCfg-1:0][63:0] cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_we && (32'(cfg_index) < NumCfg))
            cfg_reg[cfg_index] <= cfg_data;
    end

    assign busy = 1'b0;

    // HSalsa20 chain: stage i holds state after i half rounds.
    state_t  hs_reg [Half+1];
    logic [63:0] idx_reg [Half+1];
    logic [63:0] n2_reg [Half+1];
    logic [6:0]  cnt_reg [2*Half+2];
    logic [2*Half+2:0] vld_reg;
    state_t  sa_reg [Half+1];
    state_t  org_reg [Half+1];
    state_t  fin_reg;
    logic [7:0][63:0] out_reg;
    logic [6:0] cnt_out_reg;

    state_t hs_init;
    logic [6:0] cnt_sat;
    always_comb
    begin
        hs_init[0]  = Sig0;
        hs_init[1]  = cfg_reg[REG_KEY0][31:0];
        hs_init[2]  = cfg_reg[REG_KEY0][63:32];
        hs_init[3]  = cfg_reg[REG_KEY1][31:0];
        hs_init[4]  = cfg_reg[REG_KEY1][63:32];
        hs_init[5]  = Sig1;
        hs_init[6]  = cfg_reg[REG_NONCE0][31:0];
        hs_init[7]  = cfg_reg[REG_NONCE0][63:32];
        hs_init[8]  = cfg_reg[REG_NONCE1][31:0];
        hs_init[9]  = cfg_reg[REG_NONCE1][63:32];
        hs_init[10] = Sig2;
        hs_init[11] = cfg_reg[REG_KEY2][31:0];
        hs_init[12] = cfg_reg[REG_KEY2][63:32];
        hs_init[13] = cfg_reg[REG_KEY3][31:0];
        hs_init[14] = cfg_reg[REG_KEY3][63:32];
        hs_init[15] = Sig3;
        cnt_sat = (valid_bytes > 7'd64) ? 7'd64 : valid_bytes;
    end

    // Valid bits travel with each stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[2*Half+1:0], start};
    end

    always_ff @(posedge clk)
    begin
        hs_reg[0] <= hs_init;
        idx_reg[0] <= block_index;
        n2_reg[0] <= cfg_reg[REG_NONCE2];
        cnt_reg[0] <= cnt_sat;
        for (int i = 0; i < Half; i++)
        begin
            hs_reg[i+1] <= half_round(hs_reg[i], 1'(i % 2));
            n2_reg[i+1] <= n2_reg[i];
            idx_reg[i+1] <= idx_reg[i];
        end
        for (int i = 0; i < 2 * Half + 1; i++)
            cnt_reg[i+1] <= cnt_reg[i];
    end

    // Salsa20 input built from the subkey words 0,5,10,15,6,7,8,9.
    state_t sa_init;
    always_comb
    begin
        sa_init[0]  = Sig0;
        sa_init[1]  = hs_reg[Half][0];
        sa_init[2]  = hs_reg[Half][5];
        sa_init[3]  = hs_reg[Half][10];
        sa_init[4]  = hs_reg[Half][15];
        sa_init[5]  = Sig1;
        sa_init[6]  = n2_reg[Half][31:0];
        sa_init[7]  = n2_reg[Half][63:32];
        sa_init[8]  = idx_reg[Half][31:0];
        sa_init[9]  = idx_reg[Half][63:32];
        sa_init[10] = Sig2;
        sa_init[11] = hs_reg[Half][6];
        sa_init[12] = hs_reg[Half][7];
        sa_init[13] = hs_reg[Half][8];
        sa_init[14] = hs_reg[Half][9];
        sa_init[15] = Sig3;
    end

    always_ff @(posedge clk)
    begin
        sa_reg[0] <= half_round(sa_init, 1'b0);
        org_reg[0] <= sa_init;
        for (int i = 0; i < Half - 1; i++)
        begin
            sa_reg[i+1] <= half_round(sa_reg[i], 1'((i + 1) % 2));
            org_reg[i+1] <= org_reg[i];
        end
        for (int j = 0; j < 16; j++)
            fin_reg[j] <= sa_reg[Half-1][j] + org_reg[Half-1][j];
    end

    // Mask bytes at or beyond the count, then register the result.
    logic [7:0][63:0] masked;
    always_comb
    begin
        for (int k = 0; k < 8; k++)
            for (int b = 0; b < 8; b++)
                masked[k][8*b +: 8] = (7'(8 * k + b) < cnt_reg[2*Half+1])
                    ? ((b < 4) ? fin_reg[2*k][8*b +: 8] : fin_reg[2*k+1][8*(b-4) +: 8])
                    : 8'h00;
    end

    always_ff @(posedge clk)
    begin
        out_reg <= masked;
        cnt_out_reg <= cnt_reg[2*Half+1];
    end

    assign done = vld_reg[2*Half+2];
    assign stream_bytes0 = out_reg[0];
    assign stream_bytes1 = out_reg[1];
    assign stream_bytes2 = out_reg[2];
    assign stream_bytes3 = out_reg[3];
    assign stream_bytes4 = out_reg[4];
    assign stream_bytes5 = out_reg[5];
    assign stream_bytes6 = out_reg[6];
    assign stream_bytes7 = out_reg[7];
    assign byte_count = cnt_out_reg;
endmodule
`default_nettype wire

>>> dv/xsalsa20_keystream_generator_unit_tb.sv
// Self-checking testbench for the XSalsa20 keystream generator unit.
`default_nettype none
module xsalsa20_keystream_generator_unit_tb;
    import xs20_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NumRounds = 10;
    // Drain wait: the full pipeline depth, with slack on top.
    localparam int DrainCycles = 4 * NumRounds + 12;
    // Register index past the end of the list; the block must ignore it.
    localparam logic [2:0] RegUnused = 3'd7;

    typedef struct {
        bit [63:0] lanes[8];
        bit [6:0]  count;
    } keyblock_t;

    // Keystream scoreboard: keeps a shadow of the key/nonce registers,
    // computes the expected block for each accepted transaction and checks
    // results in order.
    class keystream_scoreboard;
        bit [63:0] regs[NumCfg];
        keyblock_t pending[$];
        int        errors;

        function bit [31:0] rotl32(bit [31:0] v, int s);
            return (v << s) | (v >> (32 - s));
        endfunction

        function void qround(ref bit [31:0] w[16], input int a, int b, int c, int d);
            w[b] ^= rotl32(w[a] + w[d], 7);
            w[c] ^= rotl32(w[b] + w[a], 9);
            w[d] ^= rotl32(w[c] + w[b], 13);
            w[a] ^= rotl32(w[d] + w[c], 18);
        endfunction

        function void scramble(ref bit [31:0] w[16]);
            for (int r = 0; r < NumRounds; r++)
            begin
                qround(w, 0, 4, 8, 12);
                qround(w, 5, 9, 13, 1);
                qround(w, 10, 14, 2, 6);
                qround(w, 15, 3, 7, 11);
                qround(w, 0, 1, 2, 3);
                qround(w, 5, 6, 7, 4);
                qround(w, 10, 11, 8, 9);
                qround(w, 15, 12, 13, 14);
            end
        endfunction

        function void load(ref bit [31:0] w[16], input bit [31:0] k[8], bit [31:0] n[4]);
            w[0] = Sig0;
            w[5] = Sig1;
            w[10] = Sig2;
            w[15] = Sig3;
            for (int i = 0; i < 4; i++)
            begin
                w[1 + i] = k[i];
                w[11 + i] = k[4 + i];
                w[6 + i] = n[i];
            end
        endfunction

        function void write_reg(bit [2:0] idx, bit [63:0] data);
            if (idx < NumCfg)
                regs[idx] = data;
        endfunction

        // Note an accepted transaction and queue its expected keystream block.
        function void note_request(bit [63:0] blk_idx, bit [6:0] nbytes);
            bit [31:0] k[8];
            bit [31:0] sub[8];
            bit [31:0] n[4];
            bit [31:0] w[16];
            bit [31:0] init[16];
            bit [7:0]  cnt;
            keyblock_t kb;
            int        picks[8] = '{0, 5, 10, 15, 6, 7, 8, 9};
            for (int i = 0; i < 8; i++)
                k[i] = regs[i / 2][32 * (i % 2) +: 32];
            n = '{regs[REG_NONCE0][31:0], regs[REG_NONCE0][63:32],
                  regs[REG_NONCE1][31:0], regs[REG_NONCE1][63:32]};
            // HSalsa20: no feed-forward, pick the diagonal and middle words.
            load(w, k, n);
            scramble(w);
            for (int i = 0; i < 8; i++)
                sub[i] = w[picks[i]];
            n = '{regs[REG_NONCE2][31:0], regs[REG_NONCE2][63:32],
                  blk_idx[31:0], blk_idx[63:32]};
            load(w, sub, n);
            init = w;
            scramble(w);
            cnt = (nbytes > 64) ? 8'd64 : {1'b0, nbytes};
            for (int i = 0; i < 16; i++)
                w[i] += init[i];
            for (int b = 0; b < 64; b++)
                kb.lanes[b / 8][8 * (b % 8) +: 8] = (b < cnt) ? w[b / 4][8 * (b % 4) +: 8] : 8'h00;
            kb.count = cnt[6:0];
            pending.push_back(kb);
        endfunction

        function void flag(string what, bit [63:0] want, bit [63:0] got);
            errors++;
            if (errors <= 10)
                $display("MISMATCH %s: expected %h actual %h", what, want, got);
        endfunction

        // Compare one result against the oldest expected block.
        function void check_result(bit [63:0] lanes[8], bit [6:0] count);
            keyblock_t kb;
            if (pending.size() == 0)
            begin
                flag("unexpected result, lane0", 64'd0, lanes[0]);
                return;
            end
            kb = pending.pop_front();
            for (int i = 0; i < 8; i++)
                if (lanes[i] !== kb.lanes[i])
                    flag($sformatf("stream_bytes%0d", i), kb.lanes[i], lanes[i]);
            if (count !== kb.count)
                flag("byte_count", kb.count, count);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic        start = 1'b0;
    logic [63:0] block_index = '0;
    logic [6:0]  valid_bytes = '0;
    logic        busy;
    logic        done;
    logic [63:0] stream_bytes0, stream_bytes1, stream_bytes2, stream_bytes3;
    logic [63:0] stream_bytes4, stream_bytes5, stream_bytes6, stream_bytes7;
    logic [6:0]  byte_count;

    keystream_scoreboard sb = new();
    bit                  quiet_phase;

    xsalsa20_keystream_generator_unit #(.DOUBLE_ROUNDS(NumRounds)) uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .start(start), .busy(busy),
        .block_index(block_index), .valid_bytes(valid_bytes),
        .done(done),
        .stream_bytes0(stream_bytes0), .stream_bytes1(stream_bytes1),
        .stream_bytes2(stream_bytes2), .stream_bytes3(stream_bytes3),
        .stream_bytes4(stream_bytes4), .stream_bytes5(stream_bytes5),
        .stream_bytes6(stream_bytes6), .stream_bytes7(stream_bytes7),
        .byte_count(byte_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Observe the ports at each rising edge; inputs change only by
    // nonblocking assignment, so everything read here is the pre-edge value.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                sb.write_reg(cfg_index, cfg_data);
            if (start && !busy)
                sb.note_request(block_index, valid_bytes);
            if (done)
                sb.check_result('{stream_bytes0, stream_bytes1, stream_bytes2,
                                  stream_bytes3, stream_bytes4, stream_bytes5,
                                  stream_bytes6, stream_bytes7}, byte_count);
        end
    end

    // Mostly back-to-back or short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_phase || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Present one transaction and hold it until accepted; then idle for the gap from pick_gap, if any.
    task automatic send_request(input logic [63:0] blk_idx, input logic [6:0] nbytes);
        int gap;
        start <= 1'b1;
        block_index <= blk_idx;
        valid_bytes <= nbytes;
        forever
        begin
            @(negedge clk);
            if (!busy)
                break;
            @(posedge clk);
        end
        @(posedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop start and wait for the pipeline to empty before touching config.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    // Rewrite every key/nonce register, plus a write to the unused index
    // that must have no effect.
    task automatic load_keys(input logic [63:0] vals[NumCfg]);
        cfg_we <= 1'b1;
        for (int i = 0; i < NumCfg; i++)
        begin
            cfg_index <= cfg_idx_t'(i);
            cfg_data <= vals[i];
            @(posedge clk);
        end
        cfg_index <= RegUnused;
        cfg_data <= {$urandom, $urandom};
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [63:0] rand_index();
        case ($urandom_range(0, 9))
            0: return 64'd0;
            1: return '1;
            2: return {32'd0, $urandom};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [6:0] rand_count();
        // Mostly legal counts; a few zero and over-range counts.
        case ($urandom_range(0, 19))
            0: return 7'd0;
            1: return 7'($urandom_range(65, 127));
            2: return 7'd64;
            default: return 7'($urandom_range(1, 64));
        endcase
    endfunction

    initial
    begin
        logic [63:0] vals[NumCfg];
        logic [6:0]  counts[12] = '{7'd1, 7'd7, 7'd8, 7'd9, 7'd63, 7'd64,
                                     7'd0, 7'd65, 7'd127, 7'd32, 7'd64, 7'd3};
        logic [63:0] idxs[4] = '{64'd0, '1, 64'h8000_0000_0000_0000, 64'd1};

        quiet_phase = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset keys, extreme indexes, zero and over-range counts.
        for (int i = 0; i < 12; i++)
            send_request(idxs[i % 4], counts[i]);
        drain();

        // Extreme keys: all ones, then alternating bits, with a few items each.
        for (int i = 0; i < NumCfg; i++)
            vals[i] = '1;
        load_keys(vals);
        for (int i = 0; i < 6; i++)
            send_request(idxs[i % 4], counts[(i * 5) % 12]);
        drain();
        for (int i = 0; i < NumCfg; i++)
            vals[i] = (i % 2) ? 64'h5555_5555_5555_5555 : 64'haaaa_aaaa_aaaa_aaaa;
        load_keys(vals);
        for (int i = 0; i < 6; i++)
            send_request(idxs[(i + 1) % 4], counts[(i * 7) % 12]);
        drain();

        // Random phases, each under a fresh random key and nonce.
        for (int p = 0; p < 6; p++)
        begin
            for (int i = 0; i < NumCfg; i++)
                vals[i] = {$urandom, $urandom};
            load_keys(vals);
            quiet_phase = (p % 3 == 1);
            for (int i = 0; i < 170; i++)
                send_request(rand_index(), rand_count());
            drain();
        end
        quiet_phase = 1'b0;

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
`default_nettype wire
